[rtl/wbss_pkg.sv]
// wbss_pkg: shared types and constants of the wildcard byte signature scanner
// depends on nothing; used by every rtl file of the block

package wbss_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int ADDR_WIDTH  = 32;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int SEEN_W      = $clog2(MAX_PATTERN + 1);
    localparam int LEN_W       = 7;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_SCAN = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [IDX_W-1:0]      entry_index;
        logic [7:0]            entry_byte;
        logic                  entry_wildcard;
        logic [7:0]            data_byte;
        logic [ADDR_WIDTH-1:0] byte_address;
        logic                  region_start;
        logic                  region_end;
    } in_item_t;

    typedef struct packed {
        logic                  found;
        logic [ADDR_WIDTH-1:0] match_address;
    } out_item_t;

    // per-cycle control broadcast to every cell of the row
    typedef struct packed {
        logic load;
        logic shift;
        logic update;
        logic clear;
    } cell_ctl_t;

endpackage

[rtl/wbss_cell.sv]
// wbss_cell: one position of the signature row
// holds a signature entry, one window byte and one partial-match flag; uses wbss_pkg

module wbss_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  wbss_pkg::cell_ctl_t ctl,
    input  logic              sel,
    input  logic [7:0]        load_byte,
    input  logic              load_wild,
    input  logic [7:0]        cmp_byte,
    input  logic [7:0]        byte_in,
    input  logic              flag_in,
    output logic [7:0]        byte_out,
    output logic              flag_out
);
    import wbss_pkg::*;

    logic [7:0] sig_reg;
    logic       wild_reg;
    logic [7:0] win_reg;
    logic       flag_reg;
    logic       flag_next;
    logic       hit;

    assign hit = wild_reg | (sig_reg == cmp_byte);

    always_comb
    begin
        flag_next = flag_reg;
        if (ctl.clear)
        begin
            flag_next = 1'b0;
        end
        else if (ctl.update)
        begin
            flag_next = flag_in & hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && sel)
        begin
            sig_reg  <= load_byte;
            wild_reg <= load_wild;
        end
        if (ctl.shift)
        begin
            win_reg <= byte_in;
        end
    end

    assign byte_out = win_reg;
    assign flag_out = flag_reg;

endmodule

[rtl/wbss_chain.sv]
// wbss_chain: row of wbss_cell instances, window bytes and match flags pass cell to cell
// depends on wbss_pkg and wbss_cell

module wbss_chain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wbss_pkg::cell_ctl_t          ctl,
    input  logic                         restart,
    input  logic [wbss_pkg::IDX_W-1:0]   load_index,
    input  logic [7:0]                   load_byte,
    input  logic                         load_wild,
    input  logic [7:0]                   feed_byte,
    output logic [7:0]                   win_last,
    output logic [wbss_pkg::MAX_PATTERN-1:0] flags
);
    import wbss_pkg::*;

    logic [7:0] win_bytes [MAX_PATTERN];

    genvar i;
    generate
        for (i = 0; i < MAX_PATTERN; i++)
        begin : g_pos
            logic [7:0] byte_from;
            logic       flag_from;

            if (i == 0)
            begin : g_head
                // first entry always starts a fresh candidate
                assign byte_from = feed_byte;
                assign flag_from = 1'b1;
            end
            else
            begin : g_body
                // a region start drops every candidate begun before it
                assign byte_from = win_bytes[i-1];
                assign flag_from = flags[i-1] & ~restart;
            end

            wbss_cell u_pos (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .sel       (load_index == IDX_W'(i)),
                .load_byte (load_byte),
                .load_wild (load_wild),
                .cmp_byte  (feed_byte),
                .byte_in   (byte_from),
                .flag_in   (flag_from),
                .byte_out  (win_bytes[i]),
                .flag_out  (flags[i])
            );
        end
    endgenerate

    assign win_last = win_bytes[MAX_PATTERN-1];

endmodule

[rtl/wbss_out_buf.sv]
// wbss_out_buf: two-entry result queue (output register plus skid register)
// depends on wbss_pkg

module wbss_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wbss_pkg::out_item_t  push_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wbss_pkg::out_item_t  out_data,
    output logic [1:0]           held
);
    import wbss_pkg::*;

    logic      head_valid_reg, head_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t head_reg, head_next;
    out_item_t skid_reg, skid_next;
    logic      pop;
    logic      head_free;

    assign pop       = head_valid_reg & out_ready;
    assign head_free = ~head_valid_reg | pop;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (head_free)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_next       = push_data;
                skid_valid_next = push;
            end
            else
            begin
                head_next       = push_data;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;
    // entries still held after this cycle's pop
    assign held = 2'(head_valid_reg) + 2'(skid_valid_reg) - 2'(pop);

endmodule

[rtl/wildcard_byte_signature_scan.sv]
// result path: a scan byte's result is registered in the result stage (s2_*) and then in
//   the result queue before it is offered on out
// throughput: one item per cycle, scan bytes and signature loads alike, while the result
//   queue has room; a load taken while the region holds bytes starts a rebuild of the
//   match flags, replaying the window through the cell row, during which no input is taken
// reset: match flags, byte count, result state and queue clear at once; signature length 1;
//   signature entries hold nothing defined until loaded

module wildcard_byte_signature_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  wbss_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wbss_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wbss_pkg::LEN_W-1:0]    cfg_data
);
    import wbss_pkg::*;

    localparam int GATE_W = SEEN_W + 1;

    // input transfer decode
    logic in_xfer;
    logic scan_xfer;
    logic load_xfer;

    assign in_xfer   = in_valid & in_ready;
    assign scan_xfer = in_xfer & (in_data.kind == KIND_SCAN);
    assign load_xfer = in_xfer & (in_data.kind == KIND_LOAD);

    // signature length, kept as index of the last entry in use (clamped to 1..MAX_PATTERN)
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        last_idx_next = last_idx_reg;
        if (cfg_valid)
        begin
            if (cfg_data == '0)
            begin
                last_idx_next = '0;
            end
            else if (cfg_data > LEN_W'(MAX_PATTERN))
            begin
                last_idx_next = IDX_W'(MAX_PATTERN - 1);
            end
            else
            begin
                last_idx_next = IDX_W'(cfg_data - LEN_W'(1));
            end
        end
    end

    // bytes of the current region, saturating at the row length
    logic [SEEN_W-1:0] bytes_seen_reg, bytes_seen_next;

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        if (scan_xfer)
        begin
            if (in_data.region_start)
            begin
                bytes_seen_next = SEEN_W'(1);
            end
            else if (bytes_seen_reg < SEEN_W'(MAX_PATTERN))
            begin
                bytes_seen_next = bytes_seen_reg + SEEN_W'(1);
            end
        end
    end

    // flag rebuild after a signature load: the window rotates once round the row,
    // oldest byte first, and only bytes of the current region update the flags
    logic             replay_busy_reg, replay_busy_next;
    logic [IDX_W-1:0] replay_cnt_reg, replay_cnt_next;
    logic             replay_gate;

    assign replay_gate = (GATE_W'(replay_cnt_reg) + GATE_W'(bytes_seen_reg))
                         >= GATE_W'(MAX_PATTERN);

    always_comb
    begin
        replay_busy_next = replay_busy_reg;
        replay_cnt_next  = '0;
        if (replay_busy_reg)
        begin
            replay_cnt_next = replay_cnt_reg + IDX_W'(1);
            if (replay_cnt_reg == IDX_W'(MAX_PATTERN - 1))
            begin
                replay_busy_next = 1'b0;
            end
        end
        else if (load_xfer && (bytes_seen_reg != '0))
        begin
            replay_busy_next = 1'b1;
        end
    end

    // cell row: flag i means entries 0..i match the newest i+1 bytes
    cell_ctl_t                ctl;
    logic [7:0]               win_last;
    logic [7:0]               feed_byte;
    logic [MAX_PATTERN-1:0]   flags;

    assign feed_byte  = replay_busy_reg ? win_last : in_data.data_byte;
    assign ctl.load   = load_xfer;
    assign ctl.shift  = scan_xfer | replay_busy_reg;
    assign ctl.update = scan_xfer | (replay_busy_reg & replay_gate);
    assign ctl.clear  = load_xfer;

    wbss_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .restart    (scan_xfer & in_data.region_start),
        .load_index (in_data.entry_index),
        .load_byte  (in_data.entry_byte),
        .load_wild  (in_data.entry_wildcard),
        .feed_byte  (feed_byte),
        .win_last   (win_last),
        .flags      (flags)
    );

    // result stage: reads the flags the scan byte left behind
    logic                  s2_valid_reg;
    logic [ADDR_WIDTH-1:0] s2_addr_reg;
    logic                  s2_start_reg;
    logic                  s2_end_reg;
    logic                  match_reported_reg, match_reported_next;
    logic                  reported_eff;
    logic                  hit;
    logic                  push;
    out_item_t             push_data;

    assign reported_eff = s2_start_reg ? 1'b0 : match_reported_reg;
    assign hit          = flags[last_idx_reg];
    assign push         = s2_valid_reg & ~reported_eff & (hit | s2_end_reg);

    always_comb
    begin
        push_data.found         = hit;
        push_data.match_address = '0;
        if (hit)
        begin
            // start of the match; the subtraction wraps if it falls below address zero
            push_data.match_address = s2_addr_reg - ADDR_WIDTH'(last_idx_reg);
        end
        match_reported_next = match_reported_reg;
        if (s2_valid_reg)
        begin
            match_reported_next = reported_eff | hit | s2_end_reg;
        end
    end

    // result queue
    logic [1:0] buf_held;
    logic [1:0] pending;

    wbss_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .held      (buf_held)
    );

    // take an item only while no rebuild runs and the queue has room for every result still in flight
    assign pending  = buf_held + 2'(s2_valid_reg);
    assign in_ready = ~replay_busy_reg & (pending <= 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx_reg       <= '0;
            bytes_seen_reg     <= '0;
            replay_busy_reg    <= 1'b0;
            replay_cnt_reg     <= '0;
            s2_valid_reg       <= 1'b0;
            match_reported_reg <= 1'b0;
        end
        else
        begin
            last_idx_reg       <= last_idx_next;
            bytes_seen_reg     <= bytes_seen_next;
            replay_busy_reg    <= replay_busy_next;
            replay_cnt_reg     <= replay_cnt_next;
            s2_valid_reg       <= scan_xfer;
            match_reported_reg <= match_reported_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_xfer)
        begin
            s2_addr_reg  <= in_data.byte_address;
            s2_start_reg <= in_data.region_start;
            s2_end_reg   <= in_data.region_end;
        end
    end

`ifndef SYNTH
    // a result never arrives when both queue entries are taken
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (buf_held == 2'd2)) |-> 1'b0)
        else $error("result queue overflow");

    // after a result, the region stays quiet until its next start
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && match_reported_reg && !s2_start_reg) |-> !push)
        else $error("second result in one region");

    // flag rebuild always runs the full rotation
    a_replay_len: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(replay_busy_reg) |-> ($past(replay_cnt_reg) == IDX_W'(MAX_PATTERN - 1)))
        else $error("window rotation cut short");

    // no scan byte slips into the row during a rebuild
    a_replay_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        replay_busy_reg |=> (bytes_seen_reg == $past(bytes_seen_reg)))
        else $error("byte count moved during rebuild");
`endif

endmodule
